### rtl/csf_pkg.sv
// Shared constants and types for the case-folded substring filter.
package csf_pkg;

   localparam int PATTERN_MAX_DEFAULT = 16;
   localparam int NAME_BYTES_DEFAULT  = 63;

   localparam int PATTERN_WORD_BITS = 64;
   localparam int LENGTH_BITS       = 5;
   localparam int TEXT_BITS         = 7;
   localparam int PBYTE_BITS        = 8;
   localparam int COUNT_BITS        = 16;

   localparam logic [8:0] CASE_SPLIT  = 9'd96;
   localparam logic [8:0] CASE_OFFSET = 9'd32;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Register indexes on the csr channel
   localparam logic [1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

   // Per-transaction control broadcast to every cell
   typedef struct packed {
      logic update;  // byte is compared and shifted in
      logic fresh;   // first of list: drop previous vector
      logic drop;    // last of name: clear after this byte
   } cell_ctrl_type;

endpackage

### rtl/case_folded_substring_filter.sv
// Each name's result is registered onto rsp in the cycle after its last byte is accepted.
// One byte per cycle while req_tready is high; the shift-and cells update together.
// A result waiting in the output register stalls req only while rsp_tready is low.
// Reset (synchronous, active high) clears the pattern registers, the match vector,
// the found flag, the byte position, the match count and the output valid.
module case_folded_substring_filter #(
   parameter int PATTERN_MAX = csf_pkg::PATTERN_MAX_DEFAULT,
   parameter int NAME_BYTES  = csf_pkg::NAME_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] text_byte, [7] zero
   input  logic        req_tlast,   // last_of_name
   input  logic        req_tuser,   // first_of_list
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] name_matched, [16:1] match_count, [23:17] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int POS_BITS = $clog2(NAME_BYTES + 1);
   localparam logic [POS_BITS-1:0] POS_LIMIT = POS_BITS'(NAME_BYTES);
   localparam logic [csf_pkg::LENGTH_BITS-1:0] LEN_LIMIT = csf_pkg::LENGTH_BITS'(PATTERN_MAX);

   logic [csf_pkg::PATTERN_WORD_BITS-1:0] pat_low_ff;
   logic [csf_pkg::PATTERN_WORD_BITS-1:0] pat_high_ff;
   logic [csf_pkg::LENGTH_BITS-1:0]       pat_len_ff;
   logic [2*csf_pkg::PATTERN_WORD_BITS-1:0] pat_all;
   logic [csf_pkg::LENGTH_BITS-1:0]       len_eff;

   logic                          found_ff, found_in;
   logic [POS_BITS-1:0]           pos_ff, pos_in, pos_eff;
   logic [csf_pkg::COUNT_BITS-1:0] count_ff, count_in, count_eff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_match_ff, rsp_match_in;
   logic [csf_pkg::COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   logic                          accept;
   logic                          first;
   logic                          in_name;
   logic                          active;
   logic                          hit_name;
   logic                          tail_hit;
   logic [csf_pkg::TEXT_BITS-1:0] text;
   csf_pkg::cell_ctrl_type        ctrl;

   logic [PATTERN_MAX-1:0] cell_bit;
   logic [PATTERN_MAX-1:0] cell_next;
   logic [PATTERN_MAX-1:0] cell_link;
   logic [PATTERN_MAX-1:0] cell_en;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign text       = req_tdata[csf_pkg::TEXT_BITS-1:0];
   assign first      = req_tuser;

   assign pat_all = {pat_high_ff, pat_low_ff};
   assign len_eff = (pat_len_ff > LEN_LIMIT) ? LEN_LIMIT : pat_len_ff;

   assign pos_eff   = first ? '0 : pos_ff;
   assign count_eff = first ? '0 : count_ff;
   assign in_name   = pos_eff < POS_LIMIT;
   assign active    = in_name && (text != '0);

   assign ctrl.update = accept && active;
   assign ctrl.fresh  = accept && first;
   assign ctrl.drop   = accept && req_tlast;

   // Row of cells; each takes its left neighbor's bit, the head takes a one
   genvar k;
   generate
      for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
         if (k == 0) begin : g_head
            assign cell_link[k] = 1'b1;
         end else begin : g_body
            assign cell_link[k] = first ? 1'b0 : cell_bit[k-1];
         end
         assign cell_en[k] = csf_pkg::LENGTH_BITS'(k) < len_eff;

         csf_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl),
            .text_byte    (text),
            .pattern_byte (pat_all[k*csf_pkg::PBYTE_BITS +: csf_pkg::PBYTE_BITS]),
            .enable       (cell_en[k]),
            .link_in      (cell_link[k]),
            .bit_out      (cell_bit[k]),
            .bit_next     (cell_next[k])
         );
      end
   endgenerate

   // Pattern complete when the cell at length-1 is set
   always_comb begin
      tail_hit = 1'b0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (csf_pkg::LENGTH_BITS'(i + 1) == len_eff) begin
            tail_hit = tail_hit | cell_next[i];
         end
      end
   end

   always_comb begin
      found_in     = found_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_match_in = rsp_match_ff;
      rsp_count_in = rsp_count_ff;
      hit_name     = 1'b0;
      if (accept) begin
         found_in = (first ? 1'b0 : found_ff) | (active & tail_hit);
         if (active) begin
            pos_in = pos_eff + 1'b1;
         end else if (in_name) begin
            pos_in = POS_LIMIT;
         end else begin
            pos_in = pos_eff;
         end
         count_in = count_eff;
         if (req_tlast) begin
            hit_name = found_in || (len_eff == '0);
            if (hit_name && (count_eff != csf_pkg::COUNT_MAX)) begin
               count_in = count_eff + 1'b1;
            end
            rsp_valid_in = 1'b1;
            rsp_match_in = hit_name;
            rsp_count_in = count_in;
            found_in     = 1'b0;
            pos_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff   <= '0;
         pat_high_ff  <= '0;
         pat_len_ff   <= '0;
         found_ff     <= 1'b0;
         pos_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               csf_pkg::REG_PATTERN_LOW:    pat_low_ff  <= csr_data;
               csf_pkg::REG_PATTERN_HIGH:   pat_high_ff <= csr_data;
               csf_pkg::REG_PATTERN_LENGTH: pat_len_ff  <= csr_data[csf_pkg::LENGTH_BITS-1:0];
               default: ;
            endcase
         end
         found_ff     <= found_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload holds while the result waits
   always_ff @(posedge clock) begin
      rsp_match_ff <= rsp_match_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_count_ff, rsp_match_ff};

endmodule

### rtl/csf_cell.sv
// One shift-and cell: holds one partial-match bit and compares one pattern byte.
module csf_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  csf_pkg::cell_ctrl_type        ctrl,
   input  logic [csf_pkg::TEXT_BITS-1:0] text_byte,
   input  logic [csf_pkg::PBYTE_BITS-1:0] pattern_byte,
   input  logic                          enable,
   input  logic                          link_in,
   output logic                          bit_out,
   output logic                          bit_next
);

   logic       bit_ff;
   logic       bit_in;
   logic       hit;
   logic [8:0] t_ext;
   logic [8:0] p_ext;

   assign t_ext = {2'b00, text_byte};
   assign p_ext = {1'b0, pattern_byte};

   // Equal, or the other letter case on either side of the split
   assign hit = (t_ext == p_ext) ||
                ((t_ext < csf_pkg::CASE_SPLIT) && (t_ext + csf_pkg::CASE_OFFSET == p_ext)) ||
                ((t_ext > csf_pkg::CASE_SPLIT) && (t_ext == p_ext + csf_pkg::CASE_OFFSET));

   always_comb begin
      if (ctrl.update) begin
         bit_next = link_in & enable & hit;
      end else if (ctrl.fresh) begin
         bit_next = 1'b0;
      end else begin
         bit_next = bit_ff;
      end
      bit_in = ctrl.drop ? 1'b0 : bit_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign bit_out = bit_ff;

endmodule

### test/case_folded_substring_filter_tb.sv
// Self-checking testbench for the case-folded substring filter: random names, scoreboard checks.
`timescale 1ns / 100ps

module case_folded_substring_filter_tb;

   localparam int FOLD_SPLIT     = int'(csf_pkg::CASE_SPLIT);
   localparam int FOLD_OFFSET    = int'(csf_pkg::CASE_OFFSET);
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 110;
   localparam int TAIL_NAMES     = 40;

   typedef struct {
      bit                           matched;
      bit [csf_pkg::COUNT_BITS-1:0] count;
   } name_verdict_type;

   // Tracks the filter state and the verdicts still owed by the block
   class match_scoreboard;
      bit [63:0]                     pattern_lo;
      bit [63:0]                     pattern_hi;
      bit [csf_pkg::LENGTH_BITS-1:0] pattern_len;
      bit [15:0]                     vector;
      bit                            found;
      int                            position;
      bit [csf_pkg::COUNT_BITS-1:0]  match_total;
      name_verdict_type              verdicts[$];
      int                            failures;
      int                            checked;

      function void flag(string what);
         failures++;
         if (failures <= 10) $display("mismatch: %s", what);
      endfunction

      function int pending();
         return verdicts.size();
      endfunction

      function void write_reg(bit [1:0] index, bit [63:0] value);
         case (index)
            csf_pkg::REG_PATTERN_LOW: pattern_lo = value;
            csf_pkg::REG_PATTERN_HIGH: pattern_hi = value;
            csf_pkg::REG_PATTERN_LENGTH: pattern_len = value[csf_pkg::LENGTH_BITS-1:0];
            default: ;
         endcase
      endfunction

      function void clear_name();
         vector = '0;
         found = 1'b0;
         position = 0;
      endfunction

      function void note_byte(bit [6:0] text, bit last, bit first);
         int len;
         int t;
         int p;
         int k;
         bit [15:0] hits;
         bit hit;
         name_verdict_type v;
         len = (pattern_len > csf_pkg::PATTERN_MAX_DEFAULT) ? csf_pkg::PATTERN_MAX_DEFAULT
                                                            : int'(pattern_len);
         t = int'(text);
         if (first) begin
            match_total = '0;
            clear_name();
         end
         if (position < csf_pkg::NAME_BYTES_DEFAULT) begin
            if (t == 0) begin
               // zero byte ends the content of this name
               position = csf_pkg::NAME_BYTES_DEFAULT;
            end else begin
               hits = '0;
               for (k = 0; k < len; k++) begin
                  p = (k < 8) ? int'(pattern_lo[k*8 +: 8]) : int'(pattern_hi[(k-8)*8 +: 8]);
                  if (t == p || (t < FOLD_SPLIT && t + FOLD_OFFSET == p) ||
                      (t > FOLD_SPLIT && t == p + FOLD_OFFSET))
                     hits[k] = 1'b1;
               end
               vector = ((vector << 1) | 16'd1) & hits;
               if (len > 0 && vector[len-1]) found = 1'b1;
               position++;
            end
         end
         if (last) begin
            hit = found || len == 0;
            if (hit && match_total != csf_pkg::COUNT_MAX) match_total++;
            v.matched = hit;
            v.count = match_total;
            verdicts.push_back(v);
            clear_name();
         end
      endfunction

      function void check_result(bit [23:0] data);
         name_verdict_type want;
         if (verdicts.size() == 0) begin
            flag($sformatf("result %h arrived with none outstanding", data));
            return;
         end
         want = verdicts.pop_front();
         checked++;
         if (data[0] != want.matched)
            flag($sformatf("name %0d: name_matched expected %0b got %0b",
                           checked, want.matched, data[0]));
         if (data[16:1] != want.count)
            flag($sformatf("name %0d: match_count expected %0d got %0d",
                           checked, want.count, data[16:1]));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [6:0] text_byte, [7] zero
   logic        req_tlast;   // last_of_name
   logic        req_tuser;   // first_of_list
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [0] name_matched, [16:1] match_count, [23:17] zero
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [63:0] csr_data;

   match_scoreboard board = new();
   bit              steady;
   bit              stall_done;
   int              results_taken;
   int              idle_cycles;
   int              items_sent;
   bit [7:0]        cur_pattern [16];
   int              cur_len;

   case_folded_substring_filter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Monitor every channel at the rising edge and run the watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(rsp_tdata);
            results_taken++;
         end
         if (req_tvalid && req_tready) board.note_byte(req_tdata[6:0], req_tlast, req_tuser);
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_data);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[case_folded_substring_filter] ERROR");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus one long hold-off to back up the input
   initial begin
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready = 1'b0;
            hold--;
         end else if (!stall_done && results_taken >= 100) begin
            stall_done = 1'b1;
            hold = HOLD_CYCLES;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = steady || ($urandom_range(99) >= 8);
         end
      end
   end

   task automatic send_byte(bit [6:0] text, bit last, bit first);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 8) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {1'b0, text};
      req_tlast = last;
      req_tuser = first;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic write_reg(logic [1:0] index, logic [63:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drop the input, wait for every owed verdict, then allow for the registered result
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
      int k;
      settle();
      write_reg(csf_pkg::REG_PATTERN_LOW, lo);
      write_reg(csf_pkg::REG_PATTERN_HIGH, hi);
      write_reg(csf_pkg::REG_PATTERN_LENGTH, {59'd0, len});
      for (k = 0; k < 16; k++) cur_pattern[k] = (k < 8) ? lo[k*8 +: 8] : hi[(k-8)*8 +: 8];
      cur_len = (len > csf_pkg::PATTERN_MAX_DEFAULT) ? csf_pkg::PATTERN_MAX_DEFAULT : int'(len);
   endtask

   function automatic bit [6:0] filler();
      int r;
      r = $urandom_range(9);
      if (r < 7) return 7'(($urandom_range(1) ? 32'h41 : 32'h61) + $urandom_range(25));
      return 7'($urandom_range(127, 1));
   endfunction

   function automatic bit [7:0] pick_pattern_byte();
      bit [7:0] edges [9] = '{8'd0, 8'd31, 8'd64, 8'd95, 8'd96, 8'd127, 8'd128, 8'd159, 8'd255};
      int r;
      r = $urandom_range(9);
      if (r < 6) return 8'(($urandom_range(1) ? 32'h41 : 32'h61) + $urandom_range(25));
      if (r < 8) return 8'($urandom_range(127, 32));
      if (r == 8) return 8'($urandom_range(255));
      return edges[$urandom_range(8)];
   endfunction

   // Text byte that folds onto pattern byte p, or filler when none exists
   function automatic bit [6:0] twin_of(bit [7:0] p);
      int choices[$];
      if (p >= 1 && p <= 127) choices.push_back(int'(p));
      if (p >= 33 && p <= 127) choices.push_back(int'(p) - FOLD_OFFSET);
      if (p >= 65 && p <= 95) choices.push_back(int'(p) + FOLD_OFFSET);
      if (choices.size() == 0) return filler();
      return 7'(choices[$urandom_range(choices.size() - 1)]);
   endfunction

   task automatic send_name(bit new_list);
      bit [6:0] text[$];
      int kind;
      int n;
      int at;
      int k;
      int spot;
      kind = $urandom_range(99);
      if (kind < 6) begin
         send_byte(7'd0, 1'b1, new_list);
         return;
      end
      n = (kind < 16) ? $urandom_range(80, 60) : $urandom_range(24, 1);
      for (k = 0; k < n; k++) text.push_back(filler());
      // embed the pattern with random case; a copy running off the end stays partial
      if (cur_len > 0 && $urandom_range(99) < 65) begin
         at = (kind < 16) ? $urandom_range(n - 1, 40) : $urandom_range(n - 1);
         for (k = 0; k < cur_len && at + k < n; k++) text[at+k] = twin_of(cur_pattern[k]);
         if ($urandom_range(9) == 0) begin
            spot = at + $urandom_range(cur_len - 1);
            if (spot < n) text[spot] = filler();
         end
      end
      if ($urandom_range(99) < 5) text[$urandom_range(n - 1)] = 7'd0;
      for (k = 0; k < n; k++)
         send_byte(text[k], k == n - 1, (k == 0 && new_list) || $urandom_range(199) == 0);
   endtask

   initial begin
      int phase;
      int k;
      int start;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0] len;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = csf_pkg::REG_PATTERN_LOW;
      csr_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty pattern after reset: empty name and a one-byte name both match
      send_byte(7'd0, 1'b1, 1'b1);
      send_byte(7'h71, 1'b1, 1'b0);

      // "aB_" then 0x7f: every byte reached only through case folding
      configure(64'h0000_0000_7F5F_4261, 64'd0, 5'd4);
      send_byte(7'h41, 1'b0, 1'b0);
      send_byte(7'h62, 1'b0, 1'b0);
      send_byte(7'h7F, 1'b0, 1'b0);
      send_byte(7'h5F, 1'b1, 1'b0);
      // zero byte cuts the name short
      send_byte(7'h41, 1'b0, 1'b0);
      send_byte(7'd0, 1'b0, 1'b0);
      send_byte(7'h62, 1'b1, 1'b0);

      // oversized length clamps to sixteen; short name cannot hold the pattern
      configure(64'h4847_4645_4443_4241, 64'h504F_4E4D_4C4B_4A49, 5'd31);
      for (k = 0; k < 3; k++) send_byte(7'(32'h61 + k), k == 2, 1'b0);
      for (k = 0; k < 16; k++) send_byte(7'(32'h61 + k), k == 15, k == 0);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               lo = '1;
               hi = '1;
               len = 5'd31;
            end
            1: begin
               lo = '0;
               hi = '0;
               len = 5'd16;
            end
            default: begin
               for (k = 0; k < 8; k++) begin
                  lo[k*8 +: 8] = pick_pattern_byte();
                  hi[k*8 +: 8] = pick_pattern_byte();
               end
               case (phase)
                  2: len = 5'd1;
                  3: len = 5'd16;
                  4: len = 5'd0;
                  default: len = ($urandom_range(3) == 0) ? 5'($urandom_range(31, 17))
                                                          : 5'($urandom_range(8, 1));
               endcase
            end
         endcase
         configure(lo, hi, len);
         steady = (phase == 5 || phase == 6);
         start = items_sent;
         send_name($urandom_range(9) < 3);
         while (items_sent - start < PHASE_ITEMS) send_name($urandom_range(29) == 0);
      end
      steady = 1'b0;

      // close with a list of one-byte names under the empty pattern
      configure(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd0);
      for (k = 0; k < TAIL_NAMES; k++) send_byte(7'($urandom_range(127, 1)), 1'b1, k == 0);

      settle();
      repeat (2) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("[case_folded_substring_filter] OK");
      else
         $display("[case_folded_substring_filter] ERROR");
      $finish;
   end

endmodule
